// ===== rtl/core/brlc_pkg.sv =====
// Shared types and constants for the button relay latch controller.
`default_nettype none

package brlc_pkg;

    // Mask width fixed by the button and relay fields
    localparam int MASK_W       = 6;
    // Two mode bits per channel
    localparam int MODE_BITS    = 2;
    localparam int MODE_W       = MASK_W * MODE_BITS;
    localparam int DEF_CHANNELS = 6;

    // Mode bit positions inside one channel's mode pair
    localparam int MODE_RADIO     = 0;
    localparam int MODE_MOMENTARY = 1;

    typedef logic [MASK_W-1:0]    mask_t;
    typedef logic [MODE_W-1:0]    modes_t;
    typedef logic [MODE_BITS-1:0] mode_t;

    // Per-channel findings handed from a lane to the merge stage
    typedef struct packed {
        logic newp;    // new press on this channel
        logic act;     // radio activation: clears the other radio relays
        logic op_vld;  // channel acts on its own relay
        logic op_val;  // value it writes when it does
    } lane_t;

endpackage

`default_nettype wire

// ===== rtl/core/brlc_ifs.sv =====
// Handshake channel interfaces: poll input, result output and mode write port.
`default_nettype none

interface brlc_poll_if;
    import brlc_pkg::*;
    logic  valid;
    logic  ready;
    mask_t buttons_pressed;
    logic  shift_pressed;
    modport source (output valid, output buttons_pressed, output shift_pressed, input ready);
    modport sink   (input valid, input buttons_pressed, input shift_pressed, output ready);
endinterface

interface brlc_result_if;
    import brlc_pkg::*;
    logic  valid;
    logic  ready;
    mask_t relay_mask;
    logic  new_press;
    modport source (output valid, output relay_mask, output new_press, input ready);
    modport sink   (input valid, input relay_mask, input new_press, output ready);
endinterface

interface brlc_cfg_if;
    import brlc_pkg::*;
    logic   valid;
    logic   ready;
    modes_t channel_modes;
    modport source (output valid, output channel_modes, input ready);
    modport sink   (input valid, input channel_modes, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brlc_lane.sv =====
// One channel lane: classifies the channel's button event for this poll.
`default_nettype none

module brlc_lane (
    input  wire logic           pressed,
    input  wire logic           held,
    input  wire logic           start,
    input  wire logic           shift,
    input  wire brlc_pkg::mode_t mode,
    output brlc_pkg::lane_t     lane,
    output logic                held_next
);
    import brlc_pkg::*;

    logic newp;

    // Detect a press edge against the held mask
    assign newp = pressed & ~held;

    // New press: toggle off when on at the start of the poll, else turn on; momentary release turns off
    always_comb
    begin
        lane.newp   = newp;
        lane.op_val = newp & ~start;
        lane.op_vld = newp | (~pressed & mode[MODE_MOMENTARY]);
        lane.act    = newp & ~start & ~shift & mode[MODE_RADIO];
    end

    // Hold while pressed, drop on release
    assign held_next = pressed;

endmodule

`default_nettype wire

// ===== rtl/core/brlc_merge.sv =====
// Merge stage: resolves radio clears across lanes in channel order.
`default_nettype none

module brlc_merge #(
    parameter int LANES = brlc_pkg::DEF_CHANNELS
) (
    input  wire brlc_pkg::lane_t  lanes [LANES],
    input  wire logic [LANES-1:0] radio,
    input  wire logic [LANES-1:0] start,
    output logic [LANES-1:0]      relay,
    output logic                  any_new
);
    import brlc_pkg::*;

    logic [LANES-1:0] act_after;
    logic [LANES-1:0] act_before;

    // Gather radio activations from lanes above and below each channel
    always_comb
    begin
        act_after  = '0;
        act_before = '0;
        for (int j = 0; j < LANES; j++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                if (c > j)
                    act_after[j]  = act_after[j]  | lanes[c].act;
                if (c < j)
                    act_before[j] = act_before[j] | lanes[c].act;
            end
        end
    end

    // Last writer wins: later radio clear, own action, earlier radio clear, hold
    always_comb
    begin
        any_new = 1'b0;
        for (int j = 0; j < LANES; j++)
        begin
            any_new = any_new | lanes[j].newp;
            if (radio[j] && act_after[j])
                relay[j] = 1'b0;
            else if (lanes[j].op_vld)
                relay[j] = lanes[j].op_val;
            else if (radio[j] && act_before[j])
                relay[j] = 1'b0;
            else
                relay[j] = start[j];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/button_relay_latch_controller.sv =====
// Top level of the button relay latch controller.
//
// Usage:
//   poll   : one transaction per button poll (buttons_pressed, shift_pressed).
//   result : one transaction per poll (relay_mask after the poll, new_press).
//   cfg    : writes channel_modes, two bits per channel (radio, momentary);
//            always ready, write only while no poll is in flight.
// Each channel below CHANNELS has its own lane; a merge stage resolves radio exclusion
// across lanes in ascending channel order, all combinationally.
// Latency: the result is valid on the cycle after the poll is accepted.
// Throughput: one poll per cycle while the result side takes every result.
// The relay and held masks plus one result register set that figure.
// Stall: a result waiting with result.ready low holds, and poll.ready
// drops until it is taken; poll.ready rises again in the cycle it leaves.
// Reset: all relays off, no buttons held, every channel plain toggle,
// no result pending.
// Channels at or above CHANNELS (or above six) never change.
`default_nettype none

module button_relay_latch_controller #(
    parameter int CHANNELS = brlc_pkg::DEF_CHANNELS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    brlc_poll_if.sink      poll,
    brlc_result_if.source  result,
    brlc_cfg_if.sink       cfg
);
    import brlc_pkg::*;

    localparam int LIVE = (CHANNELS > MASK_W) ? MASK_W : CHANNELS;

    mask_t  relay_reg;
    mask_t  relay_next;
    mask_t  held_reg;
    mask_t  held_next;
    modes_t modes_reg;
    logic   valid_reg;
    logic   new_press_reg;
    logic   poll_fire;
    logic   any_new;

    lane_t            lanes     [LIVE];
    logic [LIVE-1:0]  lane_held;
    logic [LIVE-1:0]  lane_radio;
    logic [LIVE-1:0]  merged;

    // Accept a poll whenever the result register is free or being emptied
    assign poll.ready = !valid_reg || result.ready;
    assign poll_fire  = poll.valid && poll.ready;
    assign cfg.ready  = 1'b1;

    // Per-channel lanes
    for (genvar i = 0; i < LIVE; i++)
    begin : g_lane
        brlc_lane u_lane (
            .pressed   (poll.buttons_pressed[i]),
            .held      (held_reg[i]),
            .start     (relay_reg[i]),
            .shift     (poll.shift_pressed),
            .mode      (modes_reg[MODE_BITS*i +: MODE_BITS]),
            .lane      (lanes[i]),
            .held_next (lane_held[i])
        );
        assign lane_radio[i] = modes_reg[MODE_BITS*i + MODE_RADIO];
    end

    brlc_merge #(
        .LANES (LIVE)
    ) u_merge (
        .lanes   (lanes),
        .radio   (lane_radio),
        .start   (relay_reg[LIVE-1:0]),
        .relay   (merged),
        .any_new (any_new)
    );

    // Assemble next masks; channels without a lane keep their state
    for (genvar i = 0; i < MASK_W; i++)
    begin : g_next
        if (i < LIVE)
        begin : g_live
            assign relay_next[i] = merged[i];
            assign held_next[i]  = lane_held[i];
        end
        else
        begin : g_idle
            assign relay_next[i] = relay_reg[i];
            assign held_next[i]  = held_reg[i];
        end
    end

    // Advance channel state on each accepted poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg     <= '0;
            held_reg      <= '0;
            new_press_reg <= 1'b0;
        end
        else if (poll_fire)
        begin
            relay_reg     <= relay_next;
            held_reg      <= held_next;
            new_press_reg <= any_new;
        end
    end

    // Hold a result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (poll_fire)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    // Latch channel modes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modes_reg <= '0;
        else if (cfg.valid)
            modes_reg <= cfg.channel_modes;
    end

    assign result.valid      = valid_reg;
    assign result.relay_mask = relay_reg;
    assign result.new_press  = new_press_reg;

endmodule

`default_nettype wire

// ===== rtl/core/brlc_checker.sv =====
// Port-level checker for the button relay latch controller, bound to the top level.
`default_nettype none

module brlc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                poll_valid,
    input wire logic                poll_ready,
    input wire brlc_pkg::mask_t     buttons_pressed,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire brlc_pkg::mask_t     relay_mask,
    input wire logic                new_press
);
    import brlc_pkg::*;

    // A stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(relay_mask) && $stable(new_press))
        else $error("stalled result changed");

    // Every accepted poll shows a result on the next cycle
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && poll_ready |=> res_valid)
        else $error("accepted poll produced no result");

    // No poll is taken while a result waits on a stalled sink
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !poll_ready)
        else $error("poll accepted over a pending result");

    // A poll with no buttons down cannot report a new press
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && poll_ready && (buttons_pressed == '0) |=> !new_press)
        else $error("new press flagged with no button down");

endmodule

bind button_relay_latch_controller brlc_checker u_brlc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .poll_valid      (poll.valid),
    .poll_ready      (poll.ready),
    .buttons_pressed (poll.buttons_pressed),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .relay_mask      (result.relay_mask),
    .new_press       (result.new_press)
);

`default_nettype wire

// ===== dv/brlc_relay_checker.sv =====
// Checker for the button relay latch controller: predicts relay results and compares them.
`timescale 1ns / 1ps

module brlc_relay_checker #(
    parameter int CHANNELS = brlc_pkg::DEF_CHANNELS
) (
    input  logic          clk,
    input  logic          rst_n,
    brlc_poll_if          poll,
    brlc_result_if        result,
    brlc_cfg_if           cfg,
    output int            outstanding,
    output int            failures
);
    import brlc_pkg::*;

    typedef struct packed {
        mask_t relay;
        mask_t held;
        logic  newp;
    } poll_outcome_t;

    typedef struct packed {
        mask_t relay;
        logic  newp;
    } relay_result_t;

    modes_t        channel_modes;
    mask_t         relay_state;
    mask_t         held_buttons;
    relay_result_t expected_relays[$];

    // Work out one poll: channels in ascending order, toggle decisions from start of poll
    function automatic poll_outcome_t apply_poll(mask_t pressed, logic shift, modes_t modes,
                                                 mask_t relay, mask_t held);
        poll_outcome_t o;
        mask_t         radio;
        mask_t         start;
        int            live;
        live    = (CHANNELS > MASK_W) ? MASK_W : CHANNELS;
        radio   = '0;
        start   = relay;
        o.relay = relay;
        o.held  = held;
        o.newp  = 1'b0;
        for (int c = 0; c < live; c++)
        begin
            radio[c] = modes[MODE_BITS*c + MODE_RADIO];
        end
        for (int c = 0; c < live; c++)
        begin
            if (pressed[c])
            begin
                if (!o.held[c])
                begin
                    if (start[c])
                    begin
                        o.relay[c] = 1'b0;
                    end
                    else
                    begin
                        // Radio press knocks out the other radio relays unless shift is held
                        if (!shift && modes[MODE_BITS*c + MODE_RADIO])
                        begin
                            o.relay = o.relay & ~(radio & ~(mask_t'(1) << c));
                        end
                        o.relay[c] = 1'b1;
                    end
                    o.held[c] = 1'b1;
                    o.newp    = 1'b1;
                end
            end
            else
            begin
                o.held[c] = 1'b0;
                if (modes[MODE_BITS*c + MODE_MOMENTARY])
                begin
                    o.relay[c] = 1'b0;
                end
            end
        end
        return o;
    endfunction

    // Track mode writes, predict each poll, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        relay_result_t exp_r;
        poll_outcome_t nxt;
        if (!rst_n)
        begin
            channel_modes = '0;
            relay_state   = '0;
            held_buttons  = '0;
            expected_relays.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            // Check results first: a result at this edge belongs to an earlier poll
            if (result.valid && result.ready)
            begin
                if (expected_relays.size() == 0)
                begin
                    $error("unexpected result transaction: relay_mask %0h new_press %0b",
                           result.relay_mask, result.new_press);
                    failures <= failures + 1;
                end
                else
                begin
                    exp_r = expected_relays.pop_front();
                    if (result.relay_mask !== exp_r.relay || result.new_press !== exp_r.newp)
                    begin
                        failures <= failures + 1;
                    end
                    if (result.relay_mask !== exp_r.relay)
                    begin
                        $error("relay_mask mismatch: expected %0h, actual %0h",
                               exp_r.relay, result.relay_mask);
                    end
                    if (result.new_press !== exp_r.newp)
                    begin
                        $error("new_press mismatch: expected %0b, actual %0b",
                               exp_r.newp, result.new_press);
                    end
                end
            end
            // Advance the predicted state on each accepted poll
            if (poll.valid && poll.ready)
            begin
                nxt = apply_poll(poll.buttons_pressed, poll.shift_pressed, channel_modes,
                                 relay_state, held_buttons);
                relay_state  = nxt.relay;
                held_buttons = nxt.held;
                exp_r.relay  = nxt.relay;
                exp_r.newp   = nxt.newp;
                expected_relays.push_back(exp_r);
            end
            // Latch the new channel modes
            if (cfg.valid && cfg.ready)
            begin
                channel_modes = cfg.channel_modes;
            end
            outstanding <= expected_relays.size();
        end
    end

endmodule

// ===== dv/tb_button_relay_latch_controller.sv =====
// Testbench top for the button relay latch controller: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_button_relay_latch_controller;
    import brlc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 100;

    logic clk = 1'b0;
    logic rst_n;
    int   outstanding;
    int   failures;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    brlc_poll_if   poll_ch();
    brlc_result_if result_ch();
    brlc_cfg_if    cfg_ch();

    button_relay_latch_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    brlc_relay_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll        (poll_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always #6 clk = ~clk;

    // Stall the result side at the current phase's rate
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one poll, idling first at the current rate, and hold until accepted
    task automatic send_poll(input mask_t buttons, input logic shift);
        while ($urandom_range(99) < send_idle_pct)
        begin
            poll_ch.valid <= 1'b0;
            @(posedge clk);
        end
        poll_ch.valid           <= 1'b1;
        poll_ch.buttons_pressed <= buttons;
        poll_ch.shift_pressed   <= shift;
        @(posedge clk);
        while (!poll_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        poll_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // Write the channel modes; call only after a drain
    task automatic write_modes(input modes_t modes);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.channel_modes <= modes;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        mask_t  buttons;
        logic   shift;
        modes_t modes_sel;
        rst_n                   <= 1'b0;
        poll_ch.valid           <= 1'b0;
        poll_ch.buttons_pressed <= '0;
        poll_ch.shift_pressed   <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.channel_modes    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Plain toggle from reset: all on, held, release, all off
        send_poll(6'h00, 1'b0);
        send_poll(6'h3f, 1'b0);
        send_poll(6'h3f, 1'b1);
        send_poll(6'h00, 1'b0);
        send_poll(6'h3f, 1'b0);
        send_poll(6'h00, 1'b0);

        // All radio: exclusion, shift override, toggle decided from start of poll
        drain_results();
        write_modes(12'h555);
        send_poll(6'h01, 1'b0);
        send_poll(6'h00, 1'b0);
        send_poll(6'h02, 1'b0);
        send_poll(6'h00, 1'b0);
        send_poll(6'h04, 1'b1);
        send_poll(6'h00, 1'b0);
        send_poll(6'h03, 1'b0);
        send_poll(6'h00, 1'b0);

        // Radio and momentary together
        drain_results();
        write_modes(12'hfff);
        send_poll(6'h01, 1'b0);
        send_poll(6'h01, 1'b0);
        send_poll(6'h02, 1'b0);
        send_poll(6'h00, 1'b0);
        send_poll(6'h3f, 1'b0);
        send_poll(6'h00, 1'b1);
        send_poll(6'h2a, 1'b1);

        // Random segments: rotate idling phases and channel modes
        buttons = '0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            case (seg)
                0:       modes_sel = 12'h000;
                1:       modes_sel = 12'hfff;
                3:       modes_sel = 12'h555;
                4:       modes_sel = 12'haaa;
                default: modes_sel = modes_t'($urandom_range(4095));
            endcase
            write_modes(modes_sel);
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                // Mostly press or release one or two buttons; sometimes jump anywhere
                if ($urandom_range(9) < 7)
                begin
                    buttons[$urandom_range(MASK_W-1)] ^= 1'b1;
                    if ($urandom_range(3) == 0)
                    begin
                        buttons[$urandom_range(MASK_W-1)] ^= 1'b1;
                    end
                end
                else
                begin
                    buttons = mask_t'($urandom_range(63));
                end
                shift = ($urandom_range(3) == 0);
                send_poll(buttons, shift);
                if ($urandom_range(39) == 0)
                begin
                    drain_results();
                end
            end
        end

        // Let the last results come back, then give the verdict
        drain_results();
        repeat (3) @(posedge clk);
        if (failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
